/* rtl/skc_pkg.sv */
// Shared types, constants and register codes for the soft-knee compressor.
`timescale 1ns / 1ps

package skc_pkg;

   // Number of channel envelopes kept in the block.
   localparam int CHANNELS = 2;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Field widths of the channels.
   localparam int CHAN_FIELD_W = 1;
   localparam int SAMPLE_W     = 24;
   localparam int GR_W         = 15;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;

   // Level and gain conversion constants.
   localparam logic signed [15:0] DB_FLOOR        = -16'sd30720;
   localparam logic [18:0]        DB_PER_LOG2_Q16 = 19'd394566;
   localparam logic [21:0]        LOG2_PER_DB_Q24 = 22'd2786635;
   localparam logic signed [14:0] GR_MIN          = -15'sd16384;

   // Horner coefficients of the 2^x cubic, in the order they are added.
   localparam logic [16:0] HORNER_SEED = 17'd5119;
   localparam logic [16:0] HORNER_C1   = 17'd14815;
   localparam logic [16:0] HORNER_C2   = 17'd45602;
   localparam logic [16:0] HORNER_C3   = 17'd65536;

   // Register reset values.
   localparam logic signed [14:0] THR_RESET   = -15'sd4608;
   localparam logic signed [15:0] SLOPE_RESET = -16'sd24576;
   localparam logic [12:0]        KNEE_RESET  = 13'd1536;
   localparam logic [23:0]        ATT_RESET   = 24'd16742303;
   localparam logic [23:0]        REL_RESET   = 24'd16773721;
   localparam logic [15:0]        MK_RESET    = 16'd4096;
   localparam logic [16:0]        MIX_RESET   = 17'd65536;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_SLOPE     = 3'd1,
      CSR_KNEE      = 3'd2,
      CSR_ATTACK    = 3'd3,
      CSR_RELEASE   = 3'd4,
      CSR_MAKEUP    = 3'd5,
      CSR_MIX       = 3'd6,
      CSR_SIDECHAIN = 3'd7
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ENV_A,
      ST_ENV_B,
      ST_NORM,
      ST_LOG,
      ST_DB,
      ST_GAIN_A,
      ST_GAIN_B,
      ST_DIV,
      ST_EXP_A,
      ST_HORNER,
      ST_EXP_B,
      ST_MAKEUP,
      ST_WET_A,
      ST_WET_B,
      ST_MIX_A,
      ST_MIX_B
   } state_type;

endpackage

/* rtl/skc_if.sv */
// Handshake channel interfaces for the compressor's input, result and register ports.
`timescale 1ns / 1ps

interface skc_req_if;
   import skc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CHAN_FIELD_W-1:0]    channel;
   logic signed [SAMPLE_W-1:0] main_sample;
   logic signed [SAMPLE_W-1:0] sidechain_sample;
   logic                       sidechain_present;

   modport source (output valid, channel, main_sample, sidechain_sample, sidechain_present,
                   input ready);
   modport sink (input valid, channel, main_sample, sidechain_sample, sidechain_present,
                 output ready);
endinterface

interface skc_rsp_if;
   import skc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic signed [GR_W-1:0]     gain_reduction_db;

   modport source (output valid, out_sample, gain_reduction_db, input ready);
   modport sink (input valid, out_sample, gain_reduction_db, output ready);
endinterface

interface skc_csr_if;
   import skc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/soft_knee_compressor_unit.sv */
// The sequence from accept to result valid is longer when the level falls
// inside the soft knee and shorter when the envelope is zero.
// One word is in work at a time; one shared 34x34 multiplier, the 16-step
// log2 squaring loop and the 14-step knee divider set the length of the sequence.
// A new word is taken while the previous result waits in the output register.
// Synchronous active-high reset loads the register defaults and clears both envelopes.
`timescale 1ns / 1ps

module soft_knee_compressor_unit (
   input logic        clock,
   input logic        reset,
   skc_req_if.sink    req_if,
   skc_rsp_if.source  rsp_if,
   skc_csr_if.sink    csr_if
);
   import skc_pkg::*;

   // Configuration registers.
   logic signed [14:0] thr_ff;
   logic signed [15:0] slope_ff;
   logic [12:0]        knee_ff;
   logic [23:0]        att_ff;
   logic [23:0]        rel_ff;
   logic [15:0]        mk_ff;
   logic [16:0]        mix_ff;
   logic               sc_ff;

   // Sequencer and working registers.
   state_type          state_ff, state_in;
   logic [31:0]        env_mem_ff [CHANNELS];
   logic [CH_W-1:0]    ch_ff;
   logic signed [23:0] dry_ff;
   logic [31:0]        x_ff;
   logic [31:0]        env_ff;
   logic [23:0]        coef_ff;
   logic signed [63:0] acc_ff;
   logic [31:0]        val_ff;
   logic [4:0]         p_ff;
   logic [3:0]         cnt_ff;
   logic [15:0]        frac_ff;
   logic signed [15:0] lvl_ff;
   logic [27:0]        t2sq_ff;
   logic [45:0]        rem_ff;
   logic [13:0]        q_ff;
   logic               neg_ff;
   logic signed [14:0] gr_ff;
   logic [3:0]         n_ff;
   logic [16:0]        xv_ff;
   logic [17:0]        hacc_ff;
   logic [31:0]        g_ff;
   logic [34:0]        gm_ff;
   logic signed [28:0] wet_ff;
   logic               rsp_valid_ff;
   logic signed [23:0] out_sample_ff;
   logic signed [14:0] out_gr_ff;

   // Shared multiplier.
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic accept, slot_free;
   assign accept    = req_if.valid && req_if.ready;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   // Clamp a reduction magnitude to the negative output range.
   function automatic logic signed [14:0] neg_clamp(input logic [19:0] m);
      logic signed [20:0] v;
      v = 21'sd0 - $signed({1'b0, m});
      neg_clamp = (m > 20'd16384) ? GR_MIN : 15'(v);
   endfunction

   // Detector source and channel selection.
   logic signed [23:0] det_sample;
   logic [23:0]        det_mag;
   logic [CH_W-1:0]    ch_sel;
   always_comb begin
      det_sample = (sc_ff && req_if.sidechain_present) ? req_if.sidechain_sample
                                                        : req_if.main_sample;
      det_mag = det_sample[23] ? 24'(-det_sample) : 24'(det_sample);
      if (32'(req_if.channel) >= 32'(CHANNELS)) begin
         ch_sel = CH_W'(CHANNELS - 1);
      end else begin
         ch_sel = CH_W'(req_if.channel);
      end
   end

   // Datapath helpers around the shared multiplier.
   logic [23:0]        coef_sel;
   logic [24:0]        coef_cmp;
   logic [63:0]        env_sum;
   logic [31:0]        env_new;
   logic [4:0]         norm_sa;
   logic               norm_top_zero;
   logic [32:0]        sq_top;
   logic [20:0]        neg_lg;
   logic [40:0]        db_sum;
   logic [16:0]        db_mag;
   logic signed [15:0] lvl_new;
   logic signed [16:0] over;
   logic signed [18:0] two_over;
   logic signed [18:0] knee_s;
   logic [18:0]        over_abs2;
   logic               below, in_knee;
   logic [13:0]        t2;
   logic [33:0]        lin_mag;
   logic [34:0]        lin_sum;
   logic signed [14:0] gr_lin;
   logic [43:0]        quad_mag;
   logic [45:0]        rem_new;
   logic [45:0]        den_sh;
   logic [46:0]        trial;
   logic               take;
   logic [13:0]        q_next;
   logic signed [14:0] gr_quad;
   logic [14:0]        gr_mag;
   logic [37:0]        e_sum;
   logic [19:0]        e_mag;
   logic [16:0]        horner_coef;
   logic [34:0]        h_sum;
   logic [17:0]        hacc_new;
   logic [4:0]         sh;
   logic [32:0]        g_num;
   logic [47:0]        gm_sum;
   logic signed [63:0] wet_full;
   logic [63:0]        wet_mag;
   logic [63:0]        wet_rnd;
   logic signed [28:0] wet_new;
   logic [16:0]        mix_c;
   logic signed [63:0] tot;
   logic [63:0]        tot_mag;
   logic [63:0]        tot_rnd;
   logic [27:0]        o_q;
   logic signed [23:0] out_new;

   always_comb begin
      // Envelope update.
      coef_sel = (x_ff > env_ff) ? att_ff : rel_ff;
      coef_cmp = 25'h1000000 - {1'b0, coef_ff};
      env_sum  = 64'(acc_ff) + 64'(mul_p[63:0]) + 64'd8388608;
      env_new  = env_sum[55:24];

      // Leading-one search, one binary step per cycle.
      norm_sa       = 5'd16 >> cnt_ff[2:0];
      norm_top_zero = (val_ff >> (6'd32 - {1'b0, norm_sa})) == 32'd0;

      // Squared mantissa for one log2 fraction bit.
      sq_top = mul_p[63:31];

      // log2 to dB.
      neg_lg  = (p_ff == 5'd31) ? 21'd0
                                : 21'({5'd31 - p_ff, 16'h0000} - {5'd0, frac_ff});
      db_sum  = mul_p[40:0] + 41'd8388608;
      db_mag  = db_sum[40:24];
      lvl_new = (db_mag > 17'd30720) ? DB_FLOOR : 16'(18'sd0 - $signed({1'b0, db_mag}));

      // Gain computer region decode.
      over      = 17'(lvl_ff) - 17'(thr_ff);
      two_over  = 19'(over) <<< 1;
      knee_s    = $signed({6'd0, knee_ff});
      below     = two_over < -knee_s;
      over_abs2 = two_over[18] ? 19'(-two_over) : 19'(two_over);
      in_knee   = (knee_ff != 13'd0) && (over_abs2 <= {6'd0, knee_ff});
      t2        = 14'(two_over + knee_s);

      // Linear branch, rounded half away from zero.
      lin_mag = mul_p[67] ? 34'(-mul_p) : 34'(mul_p);
      lin_sum = {1'b0, lin_mag} + 35'd16384;
      gr_lin  = mul_p[67] ? neg_clamp(20'(lin_sum >> 15)) : 15'sd0;

      // Quadratic branch numerator and divider step.
      quad_mag = mul_p[67] ? 44'(-mul_p) : 44'(mul_p);
      rem_new  = {2'b00, quad_mag} + {16'd0, knee_ff, 17'd0};
      den_sh   = {15'd0, knee_ff, 18'd0} << cnt_ff;
      trial    = {1'b0, rem_ff} - {1'b0, den_sh};
      take     = !trial[46];
      q_next   = {q_ff[12:0], take};
      gr_quad  = neg_ff ? neg_clamp({6'd0, q_next}) : 15'sd0;

      // Reduction to gain exponent.
      gr_mag = 15'(-gr_ff);
      e_sum  = mul_p[37:0] + 38'd32768;
      e_mag  = e_sum[35:16];

      // Horner step of the 2^x cubic.
      case (cnt_ff[1:0])
         2'd0:    horner_coef = HORNER_C1;
         2'd1:    horner_coef = HORNER_C2;
         default: horner_coef = HORNER_C3;
      endcase
      h_sum    = mul_p[34:0] + 35'd32768;
      hacc_new = 18'({1'b0, horner_coef} + h_sum[34:16]);

      // Integer part of the exponent as a rounded right shift.
      sh    = {1'b0, n_ff} + 5'd1;
      g_num = {1'b0, hacc_ff, 14'd0} + (33'd1 << (sh - 5'd1));

      // Makeup gain.
      gm_sum = mul_p[47:0] + 48'd2048;

      // Wet sample.
      wet_full = acc_ff + mul_p[63:0];
      wet_mag  = wet_full[63] ? 64'(-wet_full) : 64'(wet_full);
      wet_rnd  = wet_mag + 64'd536870912;
      wet_new  = wet_full[63] ? 29'(-$signed({1'b0, wet_rnd[58:30]}))
                              : $signed(wet_rnd[58:30]);

      // Dry and wet blend with saturation.
      mix_c   = (mix_ff > 17'h10000) ? 17'h10000 : mix_ff;
      tot     = acc_ff + mul_p[63:0];
      tot_mag = tot[63] ? 64'(-tot) : 64'(tot);
      tot_rnd = tot_mag + 64'd32768;
      o_q     = tot_rnd[43:16];
      if (!tot[63]) begin
         out_new = (o_q > 28'd8388607) ? 24'sh7FFFFF : $signed(o_q[23:0]);
      end else begin
         out_new = (o_q > 28'd8388608) ? 24'sh800000 : 24'(-$signed({1'b0, o_q}));
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_ENV_A;
         ST_ENV_A:  state_in = ST_ENV_B;
         ST_ENV_B:  state_in = (env_new == 32'd0) ? ST_GAIN_A : ST_NORM;
         ST_NORM:   if (cnt_ff == 4'd4) state_in = ST_LOG;
         ST_LOG:    if (cnt_ff == 4'd15) state_in = ST_DB;
         ST_DB:     state_in = ST_GAIN_A;
         ST_GAIN_A: state_in = (!below && in_knee) ? ST_GAIN_B : ST_EXP_A;
         ST_GAIN_B: state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == 4'd0) state_in = ST_EXP_A;
         ST_EXP_A:  state_in = ST_HORNER;
         ST_HORNER: if (cnt_ff == 4'd2) state_in = ST_EXP_B;
         ST_EXP_B:  state_in = ST_MAKEUP;
         ST_MAKEUP: state_in = ST_WET_A;
         ST_WET_A:  state_in = ST_WET_B;
         ST_WET_B:  state_in = ST_MIX_A;
         ST_MIX_A:  state_in = ST_MIX_B;
         ST_MIX_B:  if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and multiplier operand selection.
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      mul_a = 34'sd0;
      mul_b = 34'sd0;
      unique case (state_ff)
         ST_ENV_A: begin
            mul_a = $signed({10'd0, coef_sel});
            mul_b = $signed({2'd0, env_ff});
         end
         ST_ENV_B: begin
            mul_a = $signed({9'd0, coef_cmp});
            mul_b = $signed({2'd0, x_ff});
         end
         ST_LOG: begin
            mul_a = $signed({2'd0, val_ff});
            mul_b = $signed({2'd0, val_ff});
         end
         ST_DB: begin
            mul_a = $signed({13'd0, neg_lg});
            mul_b = $signed({15'd0, DB_PER_LOG2_Q16});
         end
         ST_GAIN_A: begin
            if (in_knee) begin
               mul_a = $signed({20'd0, t2});
               mul_b = $signed({20'd0, t2});
            end else begin
               mul_a = 34'(over);
               mul_b = 34'(slope_ff);
            end
         end
         ST_GAIN_B: begin
            mul_a = 34'(slope_ff);
            mul_b = $signed({6'd0, t2sq_ff});
         end
         ST_EXP_A: begin
            mul_a = $signed({19'd0, gr_mag});
            mul_b = $signed({12'd0, LOG2_PER_DB_Q24});
         end
         ST_HORNER: begin
            mul_a = $signed({16'd0, hacc_ff});
            mul_b = $signed({17'd0, xv_ff});
         end
         ST_MAKEUP: begin
            mul_a = $signed({2'd0, g_ff});
            mul_b = $signed({18'd0, mk_ff});
         end
         ST_WET_A: begin
            mul_a = 34'(dry_ff);
            mul_b = $signed({16'd0, gm_ff[34:17]});
         end
         ST_WET_B: begin
            mul_a = 34'(dry_ff);
            mul_b = $signed({17'd0, gm_ff[16:0]});
         end
         ST_MIX_A: begin
            mul_a = 34'(dry_ff);
            mul_b = $signed({17'd0, 17'h10000 - mix_c});
         end
         ST_MIX_B: begin
            mul_a = 34'(wet_ff);
            mul_b = $signed({17'd0, mix_c});
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 34'sd0;
         end
      endcase
   end

   // Configuration registers; the port never stalls.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         slope_ff <= SLOPE_RESET;
         knee_ff  <= KNEE_RESET;
         att_ff   <= ATT_RESET;
         rel_ff   <= REL_RESET;
         mk_ff    <= MK_RESET;
         mix_ff   <= MIX_RESET;
         sc_ff    <= 1'b0;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_THRESHOLD: thr_ff   <= $signed(csr_if.data[14:0]);
            CSR_SLOPE:     slope_ff <= $signed(csr_if.data[15:0]);
            CSR_KNEE:      knee_ff  <= csr_if.data[12:0];
            CSR_ATTACK:    att_ff   <= csr_if.data[23:0];
            CSR_RELEASE:   rel_ff   <= csr_if.data[23:0];
            CSR_MAKEUP:    mk_ff    <= csr_if.data[15:0];
            CSR_MIX:       mix_ff   <= csr_if.data[16:0];
            CSR_SIDECHAIN: sc_ff    <= csr_if.data[0];
            default:       sc_ff    <= sc_ff;
         endcase
      end
   end

   // Control state: sequencer, envelopes and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            env_mem_ff[i] <= 32'd0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ENV_B) begin
            env_mem_ff[ch_ff] <= env_new;
         end
         if (state_ff == ST_MIX_B && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the sequenced datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_ff  <= ch_sel;
               dry_ff <= req_if.main_sample;
               x_ff   <= {det_mag, 8'h00};
               env_ff <= env_mem_ff[ch_sel];
            end
         end
         ST_ENV_A: begin
            coef_ff <= coef_sel;
            acc_ff  <= mul_p[63:0];
         end
         ST_ENV_B: begin
            val_ff  <= env_new;
            p_ff    <= 5'd31;
            frac_ff <= 16'd0;
            cnt_ff  <= 4'd0;
            lvl_ff  <= DB_FLOOR;
         end
         ST_NORM: begin
            if (norm_top_zero) begin
               val_ff <= val_ff << norm_sa;
               p_ff   <= p_ff - norm_sa;
            end
            cnt_ff <= (cnt_ff == 4'd4) ? 4'd0 : cnt_ff + 4'd1;
         end
         ST_LOG: begin
            val_ff  <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            frac_ff <= {frac_ff[14:0], sq_top[32]};
            cnt_ff  <= cnt_ff + 4'd1;
         end
         ST_DB: begin
            lvl_ff <= lvl_new;
         end
         ST_GAIN_A: begin
            t2sq_ff <= mul_p[27:0];
            if (below) begin
               gr_ff <= 15'sd0;
            end else if (!in_knee) begin
               gr_ff <= gr_lin;
            end
         end
         ST_GAIN_B: begin
            rem_ff <= rem_new;
            neg_ff <= mul_p[67];
            q_ff   <= 14'd0;
            cnt_ff <= 4'd13;
         end
         ST_DIV: begin
            if (take) begin
               rem_ff <= trial[45:0];
            end
            q_ff   <= q_next;
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               gr_ff <= gr_quad;
            end
         end
         ST_EXP_A: begin
            n_ff    <= e_mag[19:16];
            xv_ff   <= 17'h10000 - {1'b0, e_mag[15:0]};
            hacc_ff <= {1'b0, HORNER_SEED};
            cnt_ff  <= 4'd0;
         end
         ST_HORNER: begin
            hacc_ff <= hacc_new;
            cnt_ff  <= cnt_ff + 4'd1;
         end
         ST_EXP_B: begin
            g_ff <= 32'(g_num >> sh);
         end
         ST_MAKEUP: begin
            gm_ff <= gm_sum[46:12];
         end
         ST_WET_A: begin
            acc_ff <= mul_p[63:0] <<< 17;
         end
         ST_WET_B: begin
            wet_ff <= wet_new;
         end
         ST_MIX_A: begin
            acc_ff <= mul_p[63:0];
         end
         ST_MIX_B: begin
            if (slot_free) begin
               out_sample_ff <= out_new;
               out_gr_ff     <= gr_ff;
            end
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.out_sample        = out_sample_ff;
   assign rsp_if.gain_reduction_db = out_gr_ff;

   // The squaring loop only ever sees a normalized mantissa.
   a_log_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG) |-> val_ff[31])
      else $error("log2 mantissa lost its leading one");

   // The divider walks down from bit 13.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= 4'd13))
      else $error("divider step count out of range");

   // The level into the gain computer stays between the floor and 0 dB.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GAIN_A) |-> (lvl_ff <= 16'sd0 && lvl_ff >= DB_FLOOR))
      else $error("level outside the dB range");

   // A delivered reduction never expands and never passes the clamp.
   a_gr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_gr_ff <= 15'sd0 && out_gr_ff >= GR_MIN))
      else $error("gain reduction outside its range");

   // An accepted word starts the envelope update at once.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ENV_A))
      else $error("accepted word did not start the sequence");

endmodule

/* tb/skc_tb_if.sv */
// Testbench package with the type of one predicted result word.
`timescale 1ns / 1ps

package skc_tb_pkg;
   import skc_pkg::*;

   // One predicted result word.
   typedef struct {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic signed [GR_W-1:0]     gain_reduction_db;
   } skc_result_type;
endpackage

/* tb/skc_checker.sv */
// Checker that watches the compressor's channels, predicts each result and compares it.
`timescale 1ns / 1ps

module skc_checker
   import skc_pkg::*;
   import skc_tb_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   skc_req_if     req_if,
   skc_rsp_if     rsp_if,
   skc_csr_if     csr_if,
   output int     fail_count,
   output int     pending
);

   // Shadow copy of the registers and the envelopes.
   logic [14:0] thr_q;
   logic [15:0] slope_q;
   logic [12:0] knee_q;
   logic [23:0] att_q;
   logic [23:0] rel_q;
   logic [15:0] mk_q;
   logic [16:0] mix_q;
   logic        sc_q;
   logic [31:0] env_q [CHANNELS];
   skc_result_type expected_words[$];

   // Division rounded half away from zero.
   function automatic longint div_round(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   // Envelope level in Q8.8 dB, floored.
   function automatic longint env_to_db(logic [31:0] e);
      int              lead;
      longint unsigned m;
      longint          frac;
      longint          lg;
      longint          d;
      if (e == 0) return DB_FLOOR;
      lead = 31;
      while (e[lead] == 1'b0) lead--;
      m = 64'(e) << (31 - lead);
      frac = 0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= (64'd1 << 32)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      lg = (longint'(lead) - 31) * 65536 + frac;
      lg = (lg < 0) ? -lg : 0;
      d = -((lg * 394566 + (64'sd1 <<< 23)) >>> 24);
      return (d < DB_FLOOR) ? DB_FLOOR : d;
   endfunction

   // Soft-knee gain computer.
   function automatic longint knee_curve(longint lvl);
      longint thr;
      longint s;
      longint knee;
      longint over;
      longint aover;
      longint t2;
      longint gr;
      thr = longint'($signed(thr_q));
      s = longint'($signed(slope_q));
      knee = longint'(knee_q);
      over = lvl - thr;
      if (2 * over < -knee) return 0;
      aover = (over < 0) ? -over : over;
      if (knee > 0 && 2 * aover <= knee) begin
         t2 = 2 * over + knee;
         gr = div_round(s * t2 * t2, knee <<< 18);
      end else begin
         gr = div_round(over * s, 64'sd1 <<< 15);
      end
      if (gr > 0) gr = 0;
      if (gr < -16384) gr = -16384;
      return gr;
   endfunction

   // Linear gain 2^(gr in dB / 6.02) in Q2.30.
   function automatic longint reduction_gain(longint gr);
      longint mag;
      longint n;
      longint x;
      longint acc;
      longint p;
      mag = ((-gr) * 2786635 + (64'sd1 <<< 15)) >>> 16;
      n = mag >>> 16;
      x = 65536 - (mag & 16'hFFFF);
      acc = 5119;
      acc = 14815 + ((acc * x + 32768) >>> 16);
      acc = 45602 + ((acc * x + 32768) >>> 16);
      p = 65536 + ((acc * x + 32768) >>> 16);
      if (n + 1 > 40) return 0;
      return ((p <<< 14) + (64'sd1 <<< n)) >>> (n + 1);
   endfunction

   // Works out one result word and advances the envelope.
   function automatic skc_result_type compress_word(int ch, logic signed [23:0] main_s,
                                                    logic signed [23:0] side_s, logic side_ok);
      skc_result_type r;
      longint dry;
      longint det;
      longint x;
      longint env;
      longint c;
      longint gr;
      longint gm;
      longint wet;
      longint mix;
      longint o;
      if (ch >= CHANNELS) ch = CHANNELS - 1;
      dry = longint'(main_s);
      det = (sc_q && side_ok) ? longint'(side_s) : dry;
      x = ((det < 0) ? -det : det) <<< 8;
      env = longint'(env_q[ch]);
      c = (x > env) ? longint'(att_q) : longint'(rel_q);
      env = (c * env + ((64'sd1 <<< 24) - c) * x + (64'sd1 <<< 23)) >>> 24;
      env_q[ch] = env[31:0];
      gr = knee_curve(env_to_db(env[31:0]));
      gm = (reduction_gain(gr) * longint'(mk_q) + 2048) >>> 12;
      wet = div_round(dry * gm, 64'sd1 <<< 30);
      mix = (mix_q > 17'd65536) ? 65536 : longint'(mix_q);
      o = div_round(dry * (65536 - mix) + wet * mix, 65536);
      if (o > 8388607) o = 8388607;
      if (o < -8388608) o = -8388608;
      r.out_sample = o[23:0];
      r.gain_reduction_db = gr[14:0];
      return r;
   endfunction

   assign pending = expected_words.size();

   // Track register writes, accepted words and results.
   always @(posedge clock) begin
      skc_result_type want;
      skc_result_type got;
      if (reset) begin
         thr_q <= THR_RESET;
         slope_q <= SLOPE_RESET;
         knee_q <= KNEE_RESET;
         att_q <= ATT_RESET;
         rel_q <= REL_RESET;
         mk_q <= MK_RESET;
         mix_q <= MIX_RESET;
         sc_q <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) env_q[i] = '0;
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_index_type'(csr_if.index))
               CSR_THRESHOLD: thr_q <= csr_if.data[14:0];
               CSR_SLOPE:     slope_q <= csr_if.data[15:0];
               CSR_KNEE:      knee_q <= csr_if.data[12:0];
               CSR_ATTACK:    att_q <= csr_if.data[23:0];
               CSR_RELEASE:   rel_q <= csr_if.data[23:0];
               CSR_MAKEUP:    mk_q <= csr_if.data[15:0];
               CSR_MIX:       mix_q <= csr_if.data[16:0];
               CSR_SIDECHAIN: sc_q <= csr_if.data[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            got = compress_word(int'(req_if.channel), req_if.main_sample,
                                req_if.sidechain_sample, req_if.sidechain_present);
            expected_words.insert(expected_words.size(), got);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result out=%0d gr=%0d", $time,
                        rsp_if.out_sample, rsp_if.gain_reduction_db);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (want.out_sample !== rsp_if.out_sample ||
                   want.gain_reduction_db !== rsp_if.gain_reduction_db) begin
                  $display("%0t: mismatch expected out=%0d gr=%0d actual out=%0d gr=%0d",
                           $time, want.out_sample, want.gain_reduction_db,
                           rsp_if.out_sample, rsp_if.gain_reduction_db);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/testbench.sv */
// Top of the compressor testbench: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps

module testbench;
   import skc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   idle_cycles;
   bit   long_hold;
   bit   finished;

   skc_req_if req_if ();
   skc_rsp_if rsp_if ();
   skc_csr_if csr_if ();

   soft_knee_compressor_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   skc_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one word, after a random gap when gaps is set, and waits until it is taken.
   task automatic send_word(int ch, int main_s, int side_s, bit side_ok, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      repeat (gap) @(posedge clock);
      req_if.valid <= 1'b1;
      req_if.channel <= ch[0];
      req_if.main_sample <= main_s[23:0];
      req_if.sidechain_sample <= side_s[23:0];
      req_if.sidechain_present <= side_ok;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Writes one register.
   task automatic write_reg(csr_index_type idx, int value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value[23:0];
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until no expected word is pending, then waits out the drain period.
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random sample with frequent extremes and quiet levels.
   function automatic int rand_sample();
      case ($urandom_range(0, 5))
         0: return -8388608;
         1: return 8388607;
         2: return $signed($urandom_range(0, 2047)) - 1024;
         default: return int'($urandom) >>> 8;
      endcase
   endfunction

   // Receiver: random stalls, with one long hold while the sender keeps going.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         idle_cycles <= 0;
      end else if (long_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (idle_cycles > 0) begin
         idle_cycles <= idle_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         idle_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      long_hold = 1'b0;
      wait (!reset);
      repeat (3000) @(posedge clock);
      long_hold <= 1'b1;
      repeat (600) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Watchdog on cycles with no handshake on any channel, outside the long hold and before the end.
   int stuck_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || long_hold || finished)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      finished = 1'b0;
      req_if.valid = 1'b0;
      req_if.channel = '0;
      req_if.main_sample = '0;
      req_if.sidechain_sample = '0;
      req_if.sidechain_present = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_THRESHOLD;
      csr_if.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset settings: extremes, both channels, sidechain off.
      send_word(0, 0, 0, 0, 0);
      send_word(0, 8388607, 0, 0, 0);
      send_word(1, -8388608, 8388607, 1, 0);
      send_word(0, 8388607, 0, 1, 0);
      send_word(1, 1, -1, 0, 0);
      send_word(0, -1, 0, 0, 0);
      drain();

      // Sidechain on, hard knee, steepest slope, fastest poles, maximum makeup, half mix.
      write_reg(CSR_SIDECHAIN, 1);
      write_reg(CSR_KNEE, 0);
      write_reg(CSR_SLOPE, -31130);
      write_reg(CSR_THRESHOLD, -15360);
      write_reg(CSR_ATTACK, 0);
      write_reg(CSR_RELEASE, 0);
      write_reg(CSR_MAKEUP, 64923);
      write_reg(CSR_MIX, 32768);
      send_word(0, 0, 8388607, 1, 0);
      send_word(0, 4096, -8388608, 1, 0);
      send_word(1, 8388607, 0, 0, 0);
      send_word(1, -8388608, 100, 1, 0);
      send_word(0, 12345, 0, 0, 0);
      drain();

      // Widest knee, threshold at top, positive slope, zero makeup, mix beyond full.
      write_reg(CSR_KNEE, 6144);
      write_reg(CSR_THRESHOLD, 0);
      write_reg(CSR_SLOPE, 16'h7FFF);
      write_reg(CSR_MAKEUP, 0);
      write_reg(CSR_MIX, 17'h1FFFF);
      write_reg(CSR_ATTACK, 16777215);
      write_reg(CSR_RELEASE, 16777215);
      send_word(0, 8388607, 0, 1, 0);
      send_word(1, -8388608, 0, 0, 0);
      drain();
      write_reg(CSR_MIX, 0);
      write_reg(CSR_SLOPE, -31130);
      write_reg(CSR_THRESHOLD, -4608);
      write_reg(CSR_ATTACK, 8000000);
      write_reg(CSR_RELEASE, 12000000);
      send_word(0, 8388607, 0, 0, 0);
      send_word(0, 2000000, 0, 0, 0);
      drain();

      // Random phases, each with its own random register settings.
      for (int phase = 0; phase < 10; phase++) begin
         write_reg(CSR_THRESHOLD, -$signed($urandom_range(0, 15360)));
         write_reg(CSR_SLOPE, -$signed($urandom_range(0, 31130)));
         write_reg(CSR_KNEE, (phase % 3 == 0) ? 0 : $urandom_range(0, 6144));
         write_reg(CSR_ATTACK, (phase % 2) ? $urandom_range(0, 16777215)
                                           : $urandom_range(16000000, 16777215));
         write_reg(CSR_RELEASE, (phase % 2) ? $urandom_range(0, 16777215)
                                            : $urandom_range(16000000, 16777215));
         write_reg(CSR_MAKEUP, $urandom_range(0, 64923));
         write_reg(CSR_MIX, (phase % 4 == 0) ? 65536 : $urandom_range(0, 70000));
         write_reg(CSR_SIDECHAIN, $urandom_range(0, 1));
         for (int n = 0; n < 125; n++)
            send_word($urandom_range(0, 1), rand_sample(), rand_sample(),
                      $urandom_range(0, 1), (phase % 5) != 2);
         drain();
      end

      finished = 1'b1;
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
